FILE: hw/rtl/adpcm6_block_decoder_top_assert.svh
// Assertion macros shared by the decoder RTL; clocked on clk and disabled in rst.
`ifndef ADPCM6_BLOCK_DECODER_TOP_ASSERT_SVH
`define ADPCM6_BLOCK_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADPCM6_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADPCM6_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/adpcm6_pkg.sv
// Constants, types and helper functions of the ADPCM 6-bit block decoder.
`default_nettype none

package adpcm6_pkg;

  localparam int BLOCK_DATA_BYTES      = 24;
  localparam int HISTORY_FRACTION_BITS = 16;

  localparam int HIST_W       = 48;
  localparam int BPOS_W       = $clog2(BLOCK_DATA_BYTES + 1);
  localparam int CODE_W       = 6;
  localparam int GAIN_NUM     = 1057;
  localparam int PROD_W       = 17;
  localparam int SCALE_W      = 7;
  localparam int SH_W         = 8;
  localparam int SCALE_MAX    = 32;
  localparam int WIDE_W       = PROD_W + SCALE_MAX + HISTORY_FRACTION_BITS;
  localparam int TAP_W        = 8;
  localparam int FILT_W       = HIST_W + TAP_W + 1;
  localparam int FILTER_SHIFT = 6;
  localparam int PCM_W        = 16;

  typedef logic signed [HIST_W-1:0] hist_t;
  typedef logic [CODE_W-1:0]        code_t;

  localparam hist_t HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // One decoded byte waiting for the history stage.
  typedef struct packed {
    logic [1:0] left;
    logic       fin;
    logic [1:0] sel;
    hist_t      term0;
    hist_t      term1;
  } job_t;

  function automatic logic signed [TAP_W-1:0] tap_recent(input logic [1:0] sel);
    logic signed [TAP_W-1:0] t;
    case (sel)
      2'd0:    t = TAP_W'(0);
      2'd1:    t = TAP_W'(60);
      2'd2:    t = TAP_W'(115);
      default: t = TAP_W'(98);
    endcase
    return t;
  endfunction

  function automatic logic signed [TAP_W-1:0] tap_older(input logic [1:0] sel);
    logic signed [TAP_W-1:0] t;
    case (sel)
      2'd0:    t = TAP_W'(0);
      2'd1:    t = TAP_W'(0);
      2'd2:    t = -TAP_W'(52);
      default: t = -TAP_W'(55);
    endcase
    return t;
  endfunction

  // Bit 5 set gives 1..32, otherwise 0..-31.
  function automatic logic signed [SCALE_W-1:0] header_scale(input logic [7:0] b);
    logic signed [SCALE_W-1:0] s;
    if (b[5]) begin
      s = SCALE_W'(7'd64 - {1'b0, b[5:0]});
    end else begin
      s = -$signed({2'b00, b[4:0]});
    end
    return s;
  endfunction

  // Code times gain, scaled by a power of two: floor on right shifts,
  // saturated to the history range on left shifts.
  function automatic hist_t code_term(input code_t code,
                                      input logic signed [SCALE_W-1:0] scale);
    logic signed [PROD_W-1:0] v;
    logic signed [SH_W-1:0]   sh;
    logic signed [WIDE_W-1:0] wide;
    hist_t                    r;
    v  = PROD_W'($signed(code)) * $signed(PROD_W'(GAIN_NUM));
    sh = SH_W'(scale) + SH_W'(HISTORY_FRACTION_BITS);
    if (sh < 0) begin
      wide = WIDE_W'(v) >>> (-sh);
      r    = HIST_W'(wide);
    end else begin
      wide = WIDE_W'(v) <<< sh;
      if (wide > WIDE_W'(HIST_MAX)) begin
        r = HIST_MAX;
      end else if (wide < WIDE_W'(HIST_MIN)) begin
        r = HIST_MIN;
      end else begin
        r = HIST_W'(wide);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/adpcm6_block_decoder_top.sv
// ADPCM 6-bit two-tap predictive decoder: byte parser, history stage, output register.
//
// Input channel: one compressed byte per transaction (data_byte) with
// final_byte marking the last byte of a sample. Each block is a header
// byte and then data bytes; every three data bytes carry four 6-bit codes.
// Output channel: one decoded 16-bit pcm_sample per transaction, with
// run_last set on the last sample caused by an input byte and sample_end
// copying that byte's final_byte. A header byte yields no transaction.
// The first sample of a byte passes the job register and then the output register;
// a second sample of the same byte follows it.
// The parser takes a byte in every cycle the history stage can
// hand on its job; a byte carrying two codes holds that stage until
// both codes are emitted, one after the other, because each code's
// prediction needs the history written by the code before it. The output
// rate is thus at most one sample per cycle, set by the combinational
// filter and saturation loop around the two history registers.
// Reset clears the parser (a header is expected first), the history and
// both valid flags. When the receiver stalls, the output register holds
// its sample, the history stage waits, and in_ready drops once a job waits.
`default_nettype none
`include "adpcm6_block_decoder_top_assert.svh"

module adpcm6_block_decoder_top
  import adpcm6_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    final_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PCM_W-1:0]      pcm_sample,
  output logic                         run_last,
  output logic                         sample_end
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_HOLD
  } phase_t;

  localparam logic [BPOS_W-1:0] BPOS_END = BPOS_W'(BLOCK_DATA_BYTES);
  localparam logic signed [HIST_W:0] PCM_MAX = (HIST_W+1)'(32767);
  localparam logic signed [HIST_W:0] PCM_MIN = -(HIST_W+1)'(32768);
  localparam logic [HIST_W:0] FRAC_ROUND = (HIST_W+1)'((1 << HISTORY_FRACTION_BITS) - 1);

  // Parser state.
  logic [1:0]                filter_select;
  logic signed [SCALE_W-1:0] scale_exponent;
  phase_t                    code_phase;
  logic [BPOS_W-1:0]         block_position;
  logic [7:0]                bit_holder;

  logic [1:0]                filter_select_next;
  logic signed [SCALE_W-1:0] scale_exponent_next;
  phase_t                    code_phase_next;
  logic [BPOS_W-1:0]         block_position_next;
  logic [7:0]                bit_holder_next;
  logic [BPOS_W-1:0]         bpos_inc;
  code_t                     code_a;
  code_t                     code_b;
  logic [1:0]                n_codes;

  // History stage.
  logic  job_valid;
  job_t  job;
  job_t  job_next;
  hist_t history_recent;
  hist_t history_older;

  logic                           in_accept;
  logic                           out_free;
  logic                           emit;
  logic                           last_code;
  logic                           job_done;
  logic signed [FILT_W-1:0]       filt_sum;
  logic signed [FILT_W-1:0]       filt_q;
  logic signed [FILT_W-1:0]       sum_full;
  hist_t                          sum_sat;
  logic signed [HIST_W:0]         sum_adj;
  logic signed [HIST_W:0]         int_part;
  logic signed [PCM_W-1:0]        sample;

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit      = job_valid && (job.left != 2'd0) && out_free;
  assign last_code = (job.left == 2'd1);
  assign job_done  = job_valid && ((job.left == 2'd0) || (last_code && out_free));
  assign in_ready  = !job_valid || job_done;

  // Byte parser: splits the packed codes and tracks the block layout.
  always_comb begin
    filter_select_next  = filter_select;
    scale_exponent_next = scale_exponent;
    code_phase_next     = code_phase;
    block_position_next = block_position;
    bit_holder_next     = bit_holder;
    bpos_inc            = block_position + BPOS_W'(1);
    code_a              = '0;
    code_b              = '0;
    n_codes             = 2'd0;
    if (block_position == BPOS_END) begin
      filter_select_next  = data_byte[7:6];
      scale_exponent_next = header_scale(data_byte);
      block_position_next = '0;
      code_phase_next     = PH_FIRST;
    end else begin
      unique case (code_phase) inside
        PH_FIRST: begin
          bit_holder_next = data_byte;
          code_a          = data_byte[7:2];
          n_codes         = 2'd1;
          code_phase_next = PH_SECOND;
        end
        PH_SECOND: begin
          bit_holder_next     = data_byte;
          block_position_next = bpos_inc;
          code_a              = {bit_holder[1:0], data_byte[7:4]};
          n_codes             = 2'd1;
          code_phase_next     = PH_THIRD;
        end
        PH_THIRD, PH_HOLD: begin
          code_a = {bit_holder[3:0], data_byte[7:6]};
          if (!final_byte && (bpos_inc != BPOS_END)) begin
            // The fourth code sits in the low six bits of this byte.
            code_b              = data_byte[5:0];
            n_codes             = 2'd2;
            bit_holder_next     = '0;
            block_position_next = bpos_inc + BPOS_W'(1);
            code_phase_next     = PH_FIRST;
          end else begin
            n_codes             = 2'd1;
            bit_holder_next     = data_byte;
            block_position_next = bpos_inc;
            code_phase_next     = PH_HOLD;
          end
        end
      endcase
    end
    if (final_byte) begin
      filter_select_next  = '0;
      scale_exponent_next = '0;
      code_phase_next     = PH_FIRST;
      block_position_next = BPOS_END;
      bit_holder_next     = '0;
    end
  end

  always_comb begin
    job_next.left  = n_codes;
    job_next.fin   = final_byte;
    job_next.sel   = filter_select;
    job_next.term0 = code_term(code_a, scale_exponent);
    job_next.term1 = code_term(code_b, scale_exponent);
  end

  // Prediction, saturation and conversion to a clipped integer sample.
  always_comb begin
    filt_sum = FILT_W'(tap_recent(job.sel)) * FILT_W'(history_recent)
             + FILT_W'(tap_older(job.sel)) * FILT_W'(history_older);
    filt_q   = filt_sum >>> FILTER_SHIFT;
    sum_full = FILT_W'(job.term0) + filt_q;
    if (sum_full > FILT_W'(HIST_MAX)) begin
      sum_sat = HIST_MAX;
    end else if (sum_full < FILT_W'(HIST_MIN)) begin
      sum_sat = HIST_MIN;
    end else begin
      sum_sat = HIST_W'(sum_full);
    end
    // Adding the fraction mask to negative values makes the shift truncate toward zero.
    sum_adj  = (HIST_W+1)'(sum_sat) + (sum_sat[HIST_W-1] ? $signed(FRAC_ROUND) : '0);
    int_part = sum_adj >>> HISTORY_FRACTION_BITS;
    if (int_part > PCM_MAX) begin
      sample = PCM_W'(PCM_MAX);
    end else if (int_part < PCM_MIN) begin
      sample = PCM_W'(PCM_MIN);
    end else begin
      sample = PCM_W'(int_part);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_select  <= '0;
      scale_exponent <= '0;
      code_phase     <= PH_FIRST;
      block_position <= BPOS_END;
      bit_holder     <= '0;
      job_valid      <= 1'b0;
      out_valid      <= 1'b0;
      history_recent <= '0;
      history_older  <= '0;
    end else begin
      if (in_accept) begin
        filter_select  <= filter_select_next;
        scale_exponent <= scale_exponent_next;
        code_phase     <= code_phase_next;
        block_position <= block_position_next;
        bit_holder     <= bit_holder_next;
        job_valid      <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // The sample's final byte returns the history to zero after its last code.
      if (emit && last_code && job.fin) begin
        history_recent <= '0;
        history_older  <= '0;
      end else if (emit) begin
        history_recent <= sum_sat;
        history_older  <= history_recent;
      end else if (job_valid && (job.left == 2'd0) && job.fin) begin
        history_recent <= '0;
        history_older  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job <= job_next;
    end else if (emit) begin
      job.left  <= job.left - 2'd1;
      job.term0 <= job.term1;
    end
    if (emit) begin
      pcm_sample <= sample;
      run_last   <= last_code;
      sample_end <= job.fin;
    end
  end

  `ADPCM6_ASSERT_SAME(a_bpos_range, 1'b1, block_position <= BPOS_END, "block position past end")
  `ADPCM6_ASSERT_SAME(a_job_count, job_valid, job.left != 2'd3, "job holds too many codes")
  `ADPCM6_ASSERT_NEXT(a_fin_clears, emit && last_code && job.fin, (history_recent == '0) && (history_older == '0), "history not cleared after final byte")
  `ADPCM6_ASSERT_NEXT(a_second_follows, out_valid && out_ready && !run_last, out_valid, "second sample of a byte did not follow")

endmodule

`default_nettype wire
